// ===== design/gnvs_pkg.sv =====
// Shared types and constants for the group nearest vertex search block.
// No dependencies.
`default_nettype none
package gnvs_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxRobots   = 8;
  localparam int CoordWidth  = 16;
  localparam int VtxW   = $clog2(MaxVertices);     // 10
  localparam int RobW   = $clog2(MaxRobots);       // 3
  localparam int CntW   = VtxW + 1;                // 11
  localparam int AddrW  = VtxW + RobW;
  localparam int DiffW  = CoordWidth + 1;          // 17
  localparam int SqW    = 2 * DiffW + 1;           // 35
  localparam int RootW  = (SqW + 1) / 2;           // 18
  localparam int SumW   = RootW + RobW + 1;        // 22

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  localparam logic [0:0] REG_ROBOT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SQ, ST_ROOT, ST_ACC, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic do_simple;   // handle write/target/clear, load output
    logic q_start;     // init query scan
    logic rd;          // issue memory read for current slot
    logic sq;          // square the differences
    logic root_start;  // load root unit
    logic root_step;   // one root iteration
    logic acc;         // add root, advance slot
    logic q_out;       // load query result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_empty;  // no vertices committed
    logic root_done;
    logic last_slot;   // current slot is last of last vertex
  } stat_t;
endpackage
`default_nettype wire

// ===== design/gnvs_datapath.sv =====
// Datapath: vertex memory, targets, count, distance and minimum search.
// Depends on gnvs_pkg.
`default_nettype none
module gnvs_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gnvs_pkg::cmd_t      cmd,
  output gnvs_pkg::stat_t          stat,
  input  wire logic [3:0]          robot_count,
  input  wire logic [1:0]          func,
  input  wire logic [2:0]          robot,
  input  wire logic signed [15:0]  pos_x,
  input  wire logic signed [15:0]  pos_y,
  output logic [9:0]               nearest_index,
  output logic                     found,
  output logic                     table_full,
  output logic [10:0]              vertex_count
);
  logic [31:0] mem [gnvs_pkg::MaxVertices*gnvs_pkg::MaxRobots];
  logic [31:0] rd_data;
  logic signed [15:0] tgt_x [gnvs_pkg::MaxRobots];
  logic signed [15:0] tgt_y [gnvs_pkg::MaxRobots];
  logic [gnvs_pkg::CntW-1:0] committed;
  logic [gnvs_pkg::VtxW-1:0] vi;
  logic [gnvs_pkg::RobW-1:0] ri;
  logic [gnvs_pkg::SqW-1:0] sq_sum;
  logic [gnvs_pkg::SqW-1:0] rem;
  logic [gnvs_pkg::RootW-1:0] root;
  logic [gnvs_pkg::RootW-1:0] cnt;
  logic [gnvs_pkg::SumW-1:0] sum, best;
  logic have;
  logic [3:0] nr;
  logic [gnvs_pkg::RobW-1:0] last_r;
  logic [gnvs_pkg::DiffW-1:0] dx, dy;
  logic signed [gnvs_pkg::DiffW-1:0] sdx, sdy;
  logic [2*gnvs_pkg::DiffW-1:0] dx2, dy2;
  logic [gnvs_pkg::SumW-1:0] sum_new;
  logic full_now;

  always_comb begin
    nr = (robot_count == 4'd0) ? 4'd1 :
         (robot_count > 4'(gnvs_pkg::MaxRobots)) ? 4'(gnvs_pkg::MaxRobots) : robot_count;
    last_r = gnvs_pkg::RobW'(nr - 4'd1);
    full_now = committed >= gnvs_pkg::CntW'(gnvs_pkg::MaxVertices);
    sdx = gnvs_pkg::DiffW'(tgt_x[ri]) - gnvs_pkg::DiffW'(signed'(rd_data[15:0]));
    sdy = gnvs_pkg::DiffW'(tgt_y[ri]) - gnvs_pkg::DiffW'(signed'(rd_data[31:16]));
    dx = sdx[gnvs_pkg::DiffW-1] ? gnvs_pkg::DiffW'(-sdx) : sdx;
    dy = sdy[gnvs_pkg::DiffW-1] ? gnvs_pkg::DiffW'(-sdy) : sdy;
    dx2 = dx * dx;
    dy2 = dy * dy;
    sum_new = sum + gnvs_pkg::SumW'(root);
    stat.scan_empty = committed == '0;
    stat.root_done = cnt == '0;
    stat.last_slot = (ri == last_r) && (gnvs_pkg::CntW'(vi) == committed - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (cmd.do_simple && func == gnvs_pkg::FUNC_WRITE && !full_now && {1'b0, robot} < nr)
      mem[{committed[gnvs_pkg::VtxW-1:0], robot}] <= {pos_y, pos_x};
    if (cmd.rd)
      rd_data <= mem[{vi, ri}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed <= '0;
      for (int i = 0; i < gnvs_pkg::MaxRobots; i++) begin
        tgt_x[i] <= '0;
        tgt_y[i] <= '0;
      end
    end else if (cmd.do_simple) begin
      unique case (gnvs_pkg::func_t'(func))
        gnvs_pkg::FUNC_WRITE:
          if (!full_now && {1'b0, robot} == nr - 4'd1) committed <= committed + 1'b1;
        gnvs_pkg::FUNC_TARGET: begin
          tgt_x[robot] <= pos_x;
          tgt_y[robot] <= pos_y;
        end
        gnvs_pkg::FUNC_CLEAR: committed <= '0;
        default: ;
      endcase
    end
  end

  // restoring root: one result bit per step, top bit pair of radicand first
  logic [gnvs_pkg::SqW+1:0] radicand;
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      vi <= '0;
      ri <= '0;
      sum <= '0;
      have <= 1'b0;
    end
    if (cmd.sq)
      sq_sum <= gnvs_pkg::SqW'(dx2) + gnvs_pkg::SqW'(dy2);
    if (cmd.root_start) begin
      radicand <= {1'b0, sq_sum, 1'b0};
      rem <= '0;
      root <= '0;
      cnt <= gnvs_pkg::RootW'(gnvs_pkg::RootW);
    end
    if (cmd.root_step) begin
      radicand <= {radicand[gnvs_pkg::SqW-1:0], 2'b00};
      cnt <= cnt - 1'b1;
      begin
        logic [gnvs_pkg::SqW+1:0] r2;
        logic [gnvs_pkg::SqW+1:0] t;
        r2 = {rem, radicand[gnvs_pkg::SqW+1:gnvs_pkg::SqW]};
        t = r2 - {gnvs_pkg::SqW'(root), 2'b01};
        if (!t[gnvs_pkg::SqW+1]) begin
          rem <= gnvs_pkg::SqW'(t);
          root <= {root[gnvs_pkg::RootW-2:0], 1'b1};
        end else begin
          rem <= gnvs_pkg::SqW'(r2);
          root <= {root[gnvs_pkg::RootW-2:0], 1'b0};
        end
      end
    end
    if (cmd.acc) begin
      if (ri == last_r) begin
        ri <= '0;
        vi <= vi + 1'b1;
        sum <= '0;
        if (!have || sum_new <= best) begin
          best <= sum_new;
          nearest_index <= vi;
          have <= 1'b1;
        end
      end else begin
        ri <= ri + 1'b1;
        sum <= sum_new;
      end
    end
    if (cmd.do_simple) begin
      nearest_index <= (func == gnvs_pkg::FUNC_WRITE && !full_now) ?
                       committed[gnvs_pkg::VtxW-1:0] : '0;
      found <= 1'b0;
      table_full <= func == gnvs_pkg::FUNC_WRITE && full_now;
      vertex_count <= (func == gnvs_pkg::FUNC_CLEAR) ? '0 :
        (func == gnvs_pkg::FUNC_WRITE && !full_now && {1'b0, robot} == nr - 4'd1) ?
        committed + 1'b1 : committed;
    end
    if (cmd.q_out) begin
      found <= !stat.scan_empty;
      if (stat.scan_empty) nearest_index <= '0;
      table_full <= 1'b0;
      vertex_count <= committed;
    end
  end
endmodule
`default_nettype wire

// ===== design/gnvs_ctrl.sv =====
// Controller state machine: sequences items and the query scan.
// Depends on gnvs_pkg.
`default_nettype none
module gnvs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic [1:0]      func,
  input  wire logic            out_fire,
  output logic                 out_busy,
  output gnvs_pkg::cmd_t       cmd,
  input  wire gnvs_pkg::stat_t stat,
  output logic                 idle
);
  gnvs_pkg::state_t state, state_next;
  // low in the first ST_ROOT cycle of each distance: that cycle loads the root unit
  logic root_loaded;

  always_comb begin
    state_next = state;
    unique case (state)
      gnvs_pkg::ST_IDLE:
        if (in_fire) begin
          if (func == gnvs_pkg::FUNC_QUERY)
            state_next = stat.scan_empty ? gnvs_pkg::ST_OUT : gnvs_pkg::ST_RD;
          else state_next = gnvs_pkg::ST_OUT;
        end
      gnvs_pkg::ST_RD:   state_next = gnvs_pkg::ST_SQ;
      gnvs_pkg::ST_SQ:   state_next = gnvs_pkg::ST_ROOT;
      gnvs_pkg::ST_ROOT: if (root_loaded && stat.root_done) state_next = gnvs_pkg::ST_ACC;
      gnvs_pkg::ST_ACC:  state_next = stat.last_slot ? gnvs_pkg::ST_OUT : gnvs_pkg::ST_RD;
      gnvs_pkg::ST_OUT:  if (out_fire) state_next = gnvs_pkg::ST_IDLE;
      default:           state_next = gnvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = state == gnvs_pkg::ST_IDLE;
    out_busy = state == gnvs_pkg::ST_OUT;
    unique case (state)
      gnvs_pkg::ST_IDLE: begin
        cmd.do_simple = in_fire && func != gnvs_pkg::FUNC_QUERY;
        cmd.q_start = in_fire && func == gnvs_pkg::FUNC_QUERY;
        cmd.q_out = in_fire && func == gnvs_pkg::FUNC_QUERY && stat.scan_empty;
      end
      gnvs_pkg::ST_RD:   cmd.rd = 1'b1;
      gnvs_pkg::ST_SQ:   cmd.sq = 1'b1;
      gnvs_pkg::ST_ROOT: begin
        cmd.root_start = !root_loaded;
        cmd.root_step = root_loaded && !stat.root_done;
      end
      gnvs_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.q_out = stat.last_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gnvs_pkg::ST_IDLE;
      root_loaded <= 1'b0;
    end else begin
      state <= state_next;
      root_loaded <= state == gnvs_pkg::ST_ROOT;
    end
  end

  property p_out_holds;
    @(posedge clk) disable iff (rst)
      (state == gnvs_pkg::ST_OUT && !out_fire) |=> state == gnvs_pkg::ST_OUT;
  endproperty
  a_out_holds: assert property (p_out_holds) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == gnvs_pkg::ST_IDLE) else $error("accept while busy");
  a_acc_once: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |=> !cmd.acc) else $error("double accumulate");
endmodule
`default_nettype wire

// ===== design/group_nearest_vertex_search.sv =====
// Top level of the group nearest vertex search block.
// Depends on gnvs_pkg, gnvs_ctrl, gnvs_datapath.
// One word in, one word out. A write, target or clear word is accepted and its
// result is then offered until taken. A query visits every committed vertex and every
// active robot in turn; each distance takes a memory read, a square, the bit-serial
// square-root unit (load, 18 steps, a finish step) and an accumulate. An empty query
// goes straight to its result.
// The next word is taken once the previous result has been taken.
`default_nettype none
module group_nearest_vertex_search (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [2:0]         robot,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [9:0]              nearest_index,
  output logic                    found,
  output logic                    table_full,
  output logic [10:0]             vertex_count
);
  logic [3:0] robot_count;
  gnvs_pkg::cmd_t cmd;
  gnvs_pkg::stat_t stat;
  logic idle, in_fire, out_fire;

  assign pready = 1'b1;
  assign in_ready = idle;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) robot_count <= 4'd1;
    else if (psel && penable && pwrite && paddr[2] == gnvs_pkg::REG_ROBOT_COUNT)
      robot_count <= pwdata[3:0];
  end
  assign prdata = (paddr[2] == gnvs_pkg::REG_ROBOT_COUNT) ? {28'd0, robot_count} : '0;

  gnvs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .func, .out_fire, .out_busy(out_valid), .cmd, .stat, .idle
  );

  gnvs_datapath u_dp (
    .clk, .rst, .cmd, .stat, .robot_count, .func, .robot, .pos_x, .pos_y,
    .nearest_index, .found, .table_full, .vertex_count
  );
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for group_nearest_vertex_search: runs directed and random words and
// checks every result against an in-bench predictor. Depends on gnvs_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
  localparam int WatchLimit = 50000;
  localparam int HoldLen    = 400;

  typedef struct {
    logic [9:0]  idx;
    logic        fnd;
    logic        full;
    logic [10:0] cnt;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] func = gnvs_pkg::FUNC_WRITE;
  logic [2:0] robot = '0;
  logic signed [15:0] pos_x = '0, pos_y = '0;
  logic out_valid, out_ready = 1'b0;
  logic [9:0] nearest_index;
  logic found, table_full;
  logic [10:0] vertex_count;

  group_nearest_vertex_search DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  int          vtx_x [0:gnvs_pkg::MaxVertices*gnvs_pkg::MaxRobots-1];
  int          vtx_y [0:gnvs_pkg::MaxVertices*gnvs_pkg::MaxRobots-1];
  bit          slot_written [0:gnvs_pkg::MaxVertices*gnvs_pkg::MaxRobots-1];
  int          tgt_x [0:gnvs_pkg::MaxRobots-1];
  int          tgt_y [0:gnvs_pkg::MaxRobots-1];
  int          committed;
  logic [3:0]  robot_cfg;

  answer_t     pending_answers[$];
  int          errors;
  int          send_idle_pct, recv_stall_pct;
  int          hold_asked, hold_seen, hold_cycles;
  int          quiet_cycles;

  function automatic int active_count();
    if (robot_cfg == 0) return 1;
    if (robot_cfg > gnvs_pkg::MaxRobots) return gnvs_pkg::MaxRobots;
    return int'(robot_cfg);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // every slot a query would read has been written since reset
  function automatic bit query_safe();
    int nr;
    nr = active_count();
    for (int i = 0; i < committed; i++)
      for (int r = 0; r < nr; r++)
        if (!slot_written[i*gnvs_pkg::MaxRobots+r]) return 0;
    return 1;
  endfunction

  function automatic answer_t predict_word(gnvs_pkg::func_t f, int rb, int x, int y);
    answer_t a;
    int nr, slot;
    longint unsigned best, sum, dx, dy;
    a = '{idx: '0, fnd: 1'b0, full: 1'b0, cnt: '0};
    nr = active_count();
    best = 0;
    case (f)
      gnvs_pkg::FUNC_WRITE: begin
        if (committed >= gnvs_pkg::MaxVertices) begin
          a.full = 1'b1;
        end else begin
          a.idx = committed[9:0];
          if (rb < nr) begin
            slot = committed * gnvs_pkg::MaxRobots + rb;
            vtx_x[slot] = x;
            vtx_y[slot] = y;
            slot_written[slot] = 1'b1;
            if (rb == nr - 1) committed++;
          end
        end
      end
      gnvs_pkg::FUNC_TARGET: begin
        tgt_x[rb] = x;
        tgt_y[rb] = y;
      end
      gnvs_pkg::FUNC_QUERY: begin
        for (int i = 0; i < committed; i++) begin
          sum = 0;
          for (int r = 0; r < nr; r++) begin
            dx = longint'(tgt_x[r]) - longint'(vtx_x[i*gnvs_pkg::MaxRobots+r]);
            dy = longint'(tgt_y[r]) - longint'(vtx_y[i*gnvs_pkg::MaxRobots+r]);
            if (longint'(dx) < 0) dx = -dx;
            if (longint'(dy) < 0) dy = -dy;
            sum += int_sqrt(dx*dx + dy*dy);
          end
          // ties go to the later vertex
          if (!a.fnd || sum <= best) begin
            best = sum;
            a.idx = i[9:0];
            a.fnd = 1'b1;
          end
        end
      end
      default: committed = 0;
    endcase
    a.cnt = committed[10:0];
    return a;
  endfunction

  task automatic send_word(gnvs_pkg::func_t f, int rb, logic [15:0] x, logic [15:0] y);
    answer_t ans;
    ans = predict_word(f, rb, int'($signed(x)), int'($signed(y)));
    pending_answers = {pending_answers, ans};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    robot    <= rb[2:0];
    pos_x    <= x;
    pos_y    <= y;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_robot_count(logic [3:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {gnvs_pkg::REG_ROBOT_COUNT, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    robot_cfg = val;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return $urandom_range(1) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stalls plus a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen   <= hold_asked;
      hold_cycles <= HoldLen - 1;
      out_ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check, sampled mid-cycle for the coming edge
  always @(negedge clk) begin
    answer_t a;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected word, index", nearest_index, 0);
      end else begin
        a = pending_answers.pop_front();
        if (nearest_index !== a.idx) report_mismatch("nearest_index", nearest_index, a.idx);
        if (found !== a.fnd)         report_mismatch("found", found, a.fnd);
        if (table_full !== a.full)   report_mismatch("table_full", table_full, a.full);
        if (vertex_count !== a.cnt)  report_mismatch("vertex_count", vertex_count, a.cnt);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("group_nearest_vertex_search test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    send_word(gnvs_pkg::FUNC_QUERY, 0, 16'h0, 16'h0);          // empty table
    send_word(gnvs_pkg::FUNC_WRITE, 0, 16'h7fff, 16'h8000);
    send_word(gnvs_pkg::FUNC_WRITE, 0, 16'h7fff, 16'h8000);     // identical: tie
    send_word(gnvs_pkg::FUNC_TARGET, 0, 16'h8000, 16'h7fff);    // largest distance
    send_word(gnvs_pkg::FUNC_QUERY, 0, 16'h0, 16'h0);
    send_word(gnvs_pkg::FUNC_WRITE, 0, 16'h8000, 16'h7fff);
    send_word(gnvs_pkg::FUNC_QUERY, 7, 16'hffff, 16'hffff);
    write_robot_count(4'd3);
    send_word(gnvs_pkg::FUNC_CLEAR, 0, 16'h0, 16'h0);
    send_word(gnvs_pkg::FUNC_WRITE, 5, 16'h1234, 16'h4321);     // robot above count: ignored
    send_word(gnvs_pkg::FUNC_WRITE, 0, 16'h0010, 16'hfff0);
    send_word(gnvs_pkg::FUNC_WRITE, 1, 16'h0000, 16'h0000);
    send_word(gnvs_pkg::FUNC_WRITE, 2, 16'hffff, 16'h0001);
    send_word(gnvs_pkg::FUNC_TARGET, 7, 16'h5555, 16'haaaa);
    send_word(gnvs_pkg::FUNC_TARGET, 2, 16'h0003, 16'h0004);
    send_word(gnvs_pkg::FUNC_QUERY, 0, 16'h0, 16'h0);
    send_word(gnvs_pkg::FUNC_CLEAR, 0, 16'h0, 16'h0);
    send_word(gnvs_pkg::FUNC_QUERY, 0, 16'h0, 16'h0);           // after clear, targets kept
    write_robot_count(4'd8);
    for (int r = 0; r < gnvs_pkg::MaxRobots; r++)
      send_word(gnvs_pkg::FUNC_WRITE, r, rand_coord(), rand_coord());
    send_word(gnvs_pkg::FUNC_QUERY, 0, 16'h0, 16'h0);
  endtask

  task automatic test_random(int n);
    int sent, nr, pick;
    sent = 0;
    nr = active_count();
    while (sent < n) begin
      pick = $urandom_range(99);
      if (committed > 24) begin
        send_word(gnvs_pkg::FUNC_CLEAR, 0, 16'h0, 16'h0);
        sent++;
      end else if (pick < 60) begin
        for (int r = 0; r < nr; r++)
          send_word(gnvs_pkg::FUNC_WRITE, r, rand_coord(), rand_coord());
        sent += nr;
      end else if (pick < 72) begin
        send_word(gnvs_pkg::FUNC_TARGET, $urandom_range(7), rand_coord(), rand_coord());
        sent++;
      end else if (pick < 86) begin
        if (query_safe())
          send_word(gnvs_pkg::FUNC_QUERY, $urandom_range(7), rand_coord(), rand_coord());
        else
          send_word(gnvs_pkg::FUNC_CLEAR, $urandom_range(7), rand_coord(), rand_coord());
        sent++;
      end else if (pick < 90) begin
        send_word(gnvs_pkg::FUNC_CLEAR, $urandom_range(7), rand_coord(), rand_coord());
        sent++;
      end else begin
        // broken sequence: any robot, may commit a partial vertex
        send_word(gnvs_pkg::FUNC_WRITE, $urandom_range(7), rand_coord(), rand_coord());
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked++;
    for (int i = 0; i < 6; i++)
      send_word(gnvs_pkg::FUNC_WRITE, 0, rand_coord(), rand_coord());
    drain();
    send_word(gnvs_pkg::FUNC_QUERY, 0, 16'h0, 16'h0);
  endtask

  initial begin
    errors = 0;
    committed = 0;
    robot_cfg = 4'd1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asked = 0;
    for (int i = 0; i < gnvs_pkg::MaxRobots; i++) begin
      tgt_x[i] = 0;
      tgt_y[i] = 0;
    end
    for (int i = 0; i < gnvs_pkg::MaxVertices*gnvs_pkg::MaxRobots; i++)
      slot_written[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    write_robot_count(4'd0);                          // acts as one robot
    test_random(16);
    write_robot_count(4'd2);
    send_idle_pct = 87;
    test_random(16);
    write_robot_count(4'd15);                         // acts as eight robots
    send_idle_pct = 0;
    recv_stall_pct = 87;
    send_word(gnvs_pkg::FUNC_CLEAR, 0, 16'h0, 16'h0);
    test_random(16);
    write_robot_count(4'd3);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    send_word(gnvs_pkg::FUNC_CLEAR, 0, 16'h0, 16'h0);
    test_random(16);
    test_backpressure();

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("group_nearest_vertex_search test passed");
    end else begin
      $display("group_nearest_vertex_search test failed");
    end
    $finish;
  end
endmodule
